### rtl/core/mwtg_pkg.sv
// Shared types, widths and constants for the multi-waveform tone generator.
// Used by the core and by its port checker; depends on nothing else.
`timescale 1ns / 1ps

package mwtg_pkg;

  // Sample and phase widths.
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 32;

  // Configuration register widths.
  localparam int WAVE_W   = 2;
  localparam int PERIOD_W = 16;
  localparam int AMP_W    = 15;
  localparam int LEVEL_W  = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [WAVE_W-1:0]   WAVE_RESET   = '0;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(102);
  localparam logic [PHASE_W-1:0]  STEP_RESET   = PHASE_W'(42267932);
  localparam logic [AMP_W-1:0]    AMP_RESET    = AMP_W'(32767);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVEFORM   = 2'd0,
    REG_PERIOD     = 2'd1,
    REG_PHASE_STEP = 2'd2,
    REG_AMPLITUDE  = 2'd3
  } reg_index_t;

  // Waveform selector codes; the fourth code outputs silence.
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd2;

  // Square wave peak and symmetric sample limit.
  localparam logic signed [SAMPLE_W-1:0] SQUARE_HI  = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 2);
  localparam logic [SAMPLE_W-1:0]        SAMPLE_LIM = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);

  // Q30 arithmetic for the sine polynomial.
  localparam int Q_W = 31;
  localparam logic [Q_W-1:0] Q30_ONE = 31'h4000_0000;

  // Odd Taylor-like coefficients of sin(pi/2 * x) in Q30, lowest order first.
  function automatic logic [Q_W-1:0] sin_coef(input logic [2:0] idx);
    logic [Q_W-1:0] c;
    unique case (idx)
      3'd0:    c = 31'd1686629713;
      3'd1:    c = 31'd693598668;
      3'd2:    c = 31'd85569306;
      3'd3:    c = 31'd5026995;
      3'd4:    c = 31'd172272;
      3'd5:    c = 31'd3864;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/multi_waveform_tone_generator_core.sv
// Multi-waveform tone generator: one signed sample per input transfer.
// Square and silence samples are chosen at the input transfer; sine and triangle
// run a stepped sequence first; the next input is taken once the sample is in the output register.
// The sine sequence runs nine products in turn through the shared 32x31 multiplier;
// the triangle sequence runs the divider that retires one quotient bit per cycle.
// Synchronous reset restores register defaults and clears counters and output valid.
`timescale 1ns / 1ps

module multi_waveform_tone_generator_core (
  input  logic clk,
  input  logic rst,
  // Input channel; s_tdata: bit 0 restart, bits 7:1 zero.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  // Output channel; m_tdata: bits 15:0 sample (signed).
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mwtg_pkg::SAMPLE_W-1:0] m_tdata,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mwtg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwtg_pkg::CFG_DATA_W-1:0] cfg_data
);

  import mwtg_pkg::*;

  localparam int PROD_W = 63;
  localparam int NUM_W  = 34;
  localparam int DVD_W  = 33;
  localparam int CNT_W  = 6;
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DVD_W - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PH, ST_ZQ, ST_SQ, ST_WL, ST_HM, ST_HS, ST_SM, ST_SC, ST_AM, ST_SF,
    ST_TA, ST_TB, ST_TC, ST_TD, ST_DV, ST_TQ, ST_FIN
  } state_t;

  // Configuration registers.
  logic [WAVE_W-1:0]   waveform;
  logic [PERIOD_W-1:0] period;
  logic [PHASE_W-1:0]  phase_step;
  logic [AMP_W-1:0]    amplitude;

  // Tone state.
  logic [PERIOD_W-1:0] position;
  logic [LEVEL_W-1:0]  level_count;
  logic                toggle_flag;

  // Sequencer and datapath registers.
  state_t               state;
  logic [LEVEL_W-1:0]   cnt;
  logic [PERIOD_W-1:0]  p_r;
  logic [PROD_W-1:0]    prod;
  logic [Q_W-1:0]       z;
  logic [1:0]           quad;
  logic [Q_W-1:0]       w;
  logic [Q_W-1:0]       acc;
  logic [NUM_W-1:0]     num;
  logic                 neg;
  logic [DVD_W-1:0]     dvd;
  logic [PERIOD_W-1:0]  rem;
  logic [CNT_W-1:0]     step_cnt;
  logic [SAMPLE_W-1:0]  res;

  // Accept-time counter update.
  logic                 accept;
  logic                 restart;
  logic [PERIOD_W-1:0]  p_eff;
  logic [PERIOD_W-1:0]  pos0;
  logic [PERIOD_W-1:0]  pos1;
  logic [PERIOD_W:0]    pos_inc;
  logic [PERIOD_W-1:0]  pos_next;
  logic                 tog0;
  logic                 tog_next;
  logic [LEVEL_W-1:0]   lvl0;
  logic [LEVEL_W-1:0]   level_next;

  // Shared multiplier operands.
  logic [31:0]          mul_a;
  logic [Q_W-1:0]       mul_b;

  // Step helpers.
  logic [Q_W-1:0]       z_calc;
  logic [LEVEL_W-1:0]   rem_sh;
  logic                 div_ge;
  logic [LEVEL_W-1:0]   rem_sub;
  logic [SAMPLE_W-1:0]  sine_mag;
  logic [SAMPLE_W-1:0]  sine_clip;
  logic [AMP_W-1:0]     tri_mag;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !rst && (state == ST_IDLE);
  assign cfg_ready = !rst;
  assign restart   = s_tdata[0];

  // Counter update for the accepted tick: restart, stale position, toggle, level.
  always_comb begin
    p_eff    = (period == '0) ? PERIOD_W'(1) : period;
    pos0     = restart ? '0 : position;
    tog0     = restart ? 1'b0 : toggle_flag;
    lvl0     = restart ? '0 : level_count;
    pos1     = (pos0 >= p_eff) ? '0 : pos0;
    tog_next = (pos1 == '0) ? ~tog0 : tog0;
    pos_inc  = {1'b0, pos1} + (PERIOD_W + 1)'(1);
    pos_next = (pos_inc >= {1'b0, p_eff}) ? '0 : pos_inc[PERIOD_W-1:0];
    case (waveform)
      WAVE_SINE: begin
        level_next = (lvl0 >= {1'b0, p_eff}) ? LEVEL_W'(1) : lvl0 + LEVEL_W'(1);
      end
      WAVE_TRIANGLE: begin
        if (tog_next) begin
          level_next = (lvl0 != LEVEL_MAX) ? lvl0 + LEVEL_W'(1) : lvl0;
        end else begin
          level_next = (lvl0 != '0) ? lvl0 - LEVEL_W'(1) : lvl0;
        end
      end
      default: level_next = lvl0;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_PH: begin
        mul_a = phase_step;
        mul_b = {14'b0, cnt};
      end
      ST_SQ: begin
        mul_a = {1'b0, z};
        mul_b = z;
      end
      ST_HM: begin
        mul_a = {1'b0, w};
        mul_b = acc;
      end
      ST_SM: begin
        mul_a = {1'b0, z};
        mul_b = acc;
      end
      ST_AM: begin
        mul_a = {17'b0, amplitude};
        mul_b = acc;
      end
      ST_TA: begin
        mul_a = {17'b0, amplitude};
        mul_b = {14'b0, cnt};
      end
      ST_TB: begin
        mul_a = {17'b0, amplitude};
        mul_b = {15'b0, p_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Quadrant fold, division step and final magnitudes.
  always_comb begin
    z_calc    = prod[30] ? (Q30_ONE - {1'b0, prod[29:0]}) : {1'b0, prod[29:0]};
    rem_sh    = {rem, dvd[DVD_W-1]};
    div_ge    = (rem_sh >= {1'b0, p_r});
    rem_sub   = rem_sh - {1'b0, p_r};
    sine_mag  = prod[45:30];
    sine_clip = (sine_mag > SAMPLE_LIM) ? SAMPLE_LIM : sine_mag;
    tri_mag   = (dvd > {18'b0, amplitude}) ? amplitude : dvd[AMP_W-1:0];
  end

  // Sequencer, registers and output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      waveform    <= WAVE_RESET;
      period      <= PERIOD_RESET;
      phase_step  <= STEP_RESET;
      amplitude   <= AMP_RESET;
      position    <= '0;
      level_count <= '0;
      toggle_flag <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        unique case (reg_index_t'(cfg_index))
          REG_WAVEFORM:   waveform   <= cfg_data[WAVE_W-1:0];
          REG_PERIOD:     period     <= cfg_data[PERIOD_W-1:0];
          REG_PHASE_STEP: phase_step <= cfg_data[PHASE_W-1:0];
          REG_AMPLITUDE:  amplitude  <= cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end

      // The output register loads a finished sample once free and empties on a transfer.
      if ((state == ST_FIN) && (!m_tvalid || m_tready)) begin
        m_tdata  <= res;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            position    <= pos_next;
            toggle_flag <= tog_next;
            level_count <= level_next;
            cnt         <= lvl0;
            p_r         <= p_eff;
            case (waveform)
              WAVE_SINE:     state <= ST_PH;
              WAVE_TRIANGLE: state <= ST_TA;
              WAVE_SQUARE: begin
                res   <= tog_next ? SQUARE_HI : -SQUARE_HI;
                state <= ST_FIN;
              end
              default: begin
                res   <= '0;
                state <= ST_FIN;
              end
            endcase
          end
        end
        // Sine: phase = step * count.
        ST_PH: begin
          prod  <= mul_a * mul_b;
          state <= ST_ZQ;
        end
        ST_ZQ: begin
          z     <= z_calc;
          quad  <= prod[31:30];
          state <= ST_SQ;
        end
        ST_SQ: begin
          prod  <= mul_a * mul_b;
          state <= ST_WL;
        end
        ST_WL: begin
          w        <= prod[60:30];
          acc      <= sin_coef(3'd5);
          step_cnt <= CNT_W'(4);
          state    <= ST_HM;
        end
        // Horner steps of the polynomial in w.
        ST_HM: begin
          prod  <= mul_a * mul_b;
          state <= ST_HS;
        end
        ST_HS: begin
          acc <= sin_coef(step_cnt[2:0]) - prod[60:30];
          if (step_cnt == '0) begin
            state <= ST_SM;
          end else begin
            step_cnt <= step_cnt - CNT_W'(1);
            state    <= ST_HM;
          end
        end
        ST_SM: begin
          prod  <= mul_a * mul_b;
          state <= ST_SC;
        end
        ST_SC: begin
          acc   <= (prod[62:30] > {2'b0, Q30_ONE}) ? Q30_ONE : prod[60:30];
          state <= ST_AM;
        end
        ST_AM: begin
          prod  <= mul_a * mul_b;
          state <= ST_SF;
        end
        ST_SF: begin
          res   <= quad[1] ? -sine_clip : sine_clip;
          state <= ST_FIN;
        end
        // Triangle: numerator 2*a*level - a*p.
        ST_TA: begin
          prod  <= mul_a * mul_b;
          state <= ST_TB;
        end
        ST_TB: begin
          num   <= {1'b0, prod[31:0], 1'b0};
          prod  <= mul_a * mul_b;
          state <= ST_TC;
        end
        ST_TC: begin
          num   <= num - {3'b0, prod[30:0]};
          state <= ST_TD;
        end
        ST_TD: begin
          neg      <= num[NUM_W-1];
          dvd      <= num[NUM_W-1] ? -num[DVD_W-1:0] : num[DVD_W-1:0];
          rem      <= '0;
          step_cnt <= DIV_LAST;
          state    <= ST_DV;
        end
        // Restoring division, one quotient bit per cycle.
        ST_DV: begin
          rem <= div_ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
          dvd <= {dvd[DVD_W-2:0], div_ge};
          if (step_cnt == '0) begin
            state <= ST_TQ;
          end else begin
            step_cnt <= step_cnt - CNT_W'(1);
          end
        end
        ST_TQ: begin
          res   <= neg ? -{1'b0, tri_mag} : {1'b0, tri_mag};
          state <= ST_FIN;
        end
        // Wait until the output register takes the sample.
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/mwtg_checker.sv
// Port-level checker for the tone generator core, attached by bind.
// Depends on mwtg_pkg for the sample width.
`timescale 1ns / 1ps

module mwtg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mwtg_pkg::SAMPLE_W-1:0] m_tdata
);

  import mwtg_pkg::*;

  // Reset leaves the core idle with an empty output register.
  a_reset_idle: assert property (@(posedge clk) rst |=> (!m_tvalid && (rst || s_tready)))
    else $error("core not idle after reset");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // One item at a time: the core is busy right after an input transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while busy");

  // Every sample passes through a state before the output register, so no result appears right away.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result appeared too early");

endmodule

bind multi_waveform_tone_generator_core mwtg_checker u_mwtg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
